FILE: hdl/olist_pkg.sv
package olist_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);

    localparam logic [2:0] K_INSERT     = 3'd0;
    localparam logic [2:0] K_REMOVE     = 3'd1;
    localparam logic [2:0] K_REMOVE_VAL = 3'd2;
    localparam logic [2:0] K_GET        = 3'd3;
    localparam logic [2:0] K_FIND       = 3'd4;
    localparam logic [2:0] K_CLEAR      = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  position;
        logic [63:0] item_value;
    } t_req;

    typedef struct packed {
        logic [63:0] read_value;
        logic [5:0]  found_position;
        logic        found;
        logic [6:0]  entry_count;
        logic [1:0]  status;
    } t_rsp;

endpackage

FILE: hdl/ordered_list_insert_remove_find_unit.sv
// order: a request that walks n entries reads them in S_RUN and registers its result word
//   in S_FINAL; rejected requests, clear and unused kinds skip S_RUN and go straight to S_FINAL
// rate: one request at a time, each walked through the single read port of the entry
//   memory one entry per cycle
// reset: synchronous, active low; the entry count goes to zero, entries keep old data
// the receiver cannot stall: o_valid is high for exactly one cycle per request
module ordered_list_insert_remove_find_unit
    import olist_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    // entry store, one read and one write per cycle
    logic [63:0] mem [CAPACITY];

    t_state r_state, n_state;

    // latched request
    logic [2:0]    r_kind,   n_kind;
    logic [6:0]    r_pos,    n_pos;
    logic [63:0]   r_val,    n_val;
    logic [1:0]    r_status, n_status;

    // walk control
    logic [AW-1:0] r_ptr,    n_ptr;    // next address to read
    logic [CW-1:0] r_left,   n_left;   // reads still to issue
    logic          r_pv,     n_pv;     // read data valid in r_q
    logic [AW-1:0] r_pa,     n_pa;     // address that r_q came from
    logic [63:0]   r_q;

    // accumulated results
    logic [CW-1:0] r_w,      n_w;      // compaction write index
    logic          r_found,  n_found;
    logic [AW-1:0] r_fpos,   n_fpos;
    logic [63:0]   r_rd,     n_rd;
    logic [CW-1:0] r_count,  n_count;

    logic          r_valid,  n_valid;
    t_rsp          r_out,    n_out;

    // memory controls
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;

    // request decode at accept time
    logic          accept;
    logic          w_run;
    logic [1:0]    w_status;
    logic [AW-1:0] w_ptr;
    logic [CW-1:0] w_left;
    logic [CW-1:0] w_pos;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign o_valid = r_valid;
    assign o_rsp   = r_out;

    // position as seen against the count
    assign w_pos = CW'(i_req.position);

    always_comb begin
        w_run    = 1'b0;
        w_status = ST_OK;
        w_ptr    = '0;
        w_left   = '0;
        case (i_req.kind)
            K_INSERT: begin
                if (r_count >= CW'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else if (w_pos > r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    // move entries count-1 down to pos up by one
                    w_run  = 1'b1;
                    w_ptr  = AW'(r_count - 1'b1);
                    w_left = r_count - w_pos;
                end
            end
            K_REMOVE: begin
                if (w_pos >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    // move entries pos+1 up to count-1 down by one
                    w_run  = 1'b1;
                    w_ptr  = AW'(w_pos + 1'b1);
                    w_left = r_count - w_pos - 1'b1;
                end
            end
            K_REMOVE_VAL, K_FIND: begin
                w_run  = 1'b1;
                w_left = r_count;
            end
            K_GET: begin
                if (w_pos >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_run  = 1'b1;
                    w_ptr  = AW'(w_pos);
                    w_left = CW'(1);
                end
            end
            default: begin
                w_run = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = w_run ? S_RUN : S_FINAL;
                end
            end
            S_RUN: begin
                // the last word read is handled in this same cycle
                if (r_left == '0) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_kind   = r_kind;
        n_pos    = r_pos;
        n_val    = r_val;
        n_status = r_status;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_pv     = 1'b0;
        n_pa     = r_ptr;
        n_w      = r_w;
        n_found  = r_found;
        n_fpos   = r_fpos;
        n_rd     = r_rd;
        n_count  = r_count;
        n_valid  = 1'b0;
        n_out    = r_out;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = r_q;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind   = i_req.kind;
                    n_pos    = i_req.position;
                    n_val    = i_req.item_value;
                    n_status = w_status;
                    n_ptr    = w_ptr;
                    n_left   = w_left;
                    n_w      = '0;
                    n_found  = 1'b0;
                    n_fpos   = '0;
                    n_rd     = '0;
                end
            end
            S_RUN: begin
                // issue the next read
                if (r_left != '0) begin
                    rd_en  = 1'b1;
                    n_pv   = 1'b1;
                    n_left = r_left - 1'b1;
                    n_ptr  = (r_kind == K_INSERT) ? r_ptr - 1'b1 : r_ptr + 1'b1;
                end
                // handle the word whose read was issued in the previous cycle
                if (r_pv) begin
                    case (r_kind)
                        K_INSERT: begin
                            wr_en   = 1'b1;
                            wr_addr = r_pa + 1'b1;
                        end
                        K_REMOVE: begin
                            wr_en   = 1'b1;
                            wr_addr = r_pa - 1'b1;
                        end
                        K_REMOVE_VAL: begin
                            if (r_q == r_val) begin
                                n_found = 1'b1;
                            end else begin
                                // compaction write stays at or below the read address
                                wr_en   = 1'b1;
                                wr_addr = r_w[AW-1:0];
                                n_w     = r_w + 1'b1;
                            end
                        end
                        K_GET: begin
                            n_rd = r_q;
                        end
                        K_FIND: begin
                            if (!r_found && (r_q[31:0] == r_val[31:0])) begin
                                n_found = 1'b1;
                                n_fpos  = r_pa;
                            end
                        end
                        default: begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            S_FINAL: begin
                if (r_status == ST_OK) begin
                    case (r_kind)
                        K_INSERT: begin
                            wr_en   = 1'b1;
                            wr_addr = r_pos[AW-1:0];
                            wr_data = r_val;
                            n_count = r_count + 1'b1;
                        end
                        K_REMOVE: begin
                            n_count = r_count - 1'b1;
                        end
                        K_REMOVE_VAL: begin
                            n_count = r_w;
                        end
                        K_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
                n_valid              = 1'b1;
                n_out.read_value     = r_rd;
                n_out.found_position = 6'(r_fpos);
                n_out.found          = r_found;
                n_out.entry_count    = 7'(n_count);
                n_out.status         = r_status;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[r_ptr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_pv    <= n_pv;
            r_left  <= n_left;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_ptr    <= n_ptr;
        r_pa     <= n_pa;
        r_w      <= n_w;
        r_found  <= n_found;
        r_fpos   <= n_fpos;
        r_rd     <= n_rd;
        r_out    <= n_out;
    end

    // the list never holds more than the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // every finished request gives exactly one result word right after
    a_final_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |=> (o_valid && !$past(o_valid)))
        else $error("result strobe missing after final step");

    // the result word appears only when the unit is ready again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while still busy");

    // a rejected request reads nothing and finds nothing
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != ST_OK)) |->
            ((o_rsp.read_value == '0) && !o_rsp.found))
        else $error("rejected request carries data");

endmodule
